// ----- src/lebc_pkg.sv -----
// ----------------------------------------------------------------------------
// lebc_pkg
// Shared types and constants of the unsigned LEB128 varint codec.
// ----------------------------------------------------------------------------
package lebc_pkg;

  // Value width of the codec; storage and ports stay 64 bits wide
  localparam int unsigned ValueBits = 64;
  localparam int unsigned DataW     = 64;
  localparam int unsigned DigitBits = 7;
  localparam int unsigned MaxBytes  = 10;
  localparam int unsigned CntW      = 4;

  // Payload bits kept from a value
  localparam logic [DataW-1:0] ValueMask =
      (ValueBits >= DataW) ? {DataW{1'b1}} : ((64'd1 << ValueBits) - 64'd1);

  // Continuation bytes taken at which a further continuation overflows
  localparam int unsigned OvfTaken = (ValueBits + DigitBits - 1) / DigitBits - 1;

  typedef enum logic [1:0] {
    MODE_ENCODE = 2'd0,
    MODE_DECODE = 2'd1,
    MODE_END    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_TRUNCATED = 2'd2,
    ERR_OVER32    = 2'd3
  } err_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_ENCODE = 1'b1
  } state_e;

  // Commands from the sequencer to the shift unit
  typedef struct packed {
    logic enc_load;
    logic enc_step;
    logic dec_step;
    logic eob;
  } ctrl_t;

  // Status from the shift unit to the sequencer
  typedef struct packed {
    logic enc_more;
    logic emit;
  } stat_t;

  // One result beat
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        out_byte;
    logic [DataW-1:0]  value;
    err_e              err;
    logic [CntW-1:0]   cnt;
    logic              last;
  } beat_t;

endpackage

// ----- src/lebc_unit.sv -----
// ----------------------------------------------------------------------------
// lebc_unit
// Shared seven-bit shift unit: encode work register and decode accumulator.
// ----------------------------------------------------------------------------
module lebc_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lebc_pkg::ctrl_t               ctrl_i,
  input  logic [lebc_pkg::DataW-1:0]    value_in_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          want_32_i,
  output lebc_pkg::stat_t               stat_o,
  output lebc_pkg::beat_t               beat_o
);
  import lebc_pkg::*;

  logic [DataW-1:0] work_q, work_d;
  logic [CntW-1:0]  enc_cnt_q, enc_cnt_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [CntW-1:0]  taken_q, taken_d;

  logic [6:0]       shift_full;
  logic [5:0]       shift_amt;
  logic [DataW-1:0] placed;
  logic [DataW-1:0] acc_sum;
  logic             enc_more;
  logic             dec_fin;
  logic             dec_ovf;
  logic             over32;

  // taken * 7
  assign shift_full = {taken_q, 3'b000} - {3'b000, taken_q};
  assign shift_amt  = shift_full[5:0];
  assign placed     = DataW'(data_byte_i[6:0]) << shift_amt;
  assign acc_sum    = (acc_q | placed) & ValueMask;

  assign enc_more = (|work_q[DataW-1:DigitBits]) && (enc_cnt_q < CntW'(MaxBytes - 1));
  assign dec_fin  = ~data_byte_i[7];
  assign dec_ovf  = data_byte_i[7] && (taken_q >= CntW'(OvfTaken));
  assign over32   = want_32_i && (|acc_sum[DataW-1:32]);

  always_comb begin
    beat_o          = '0;
    stat_o.enc_more = enc_more;
    stat_o.emit     = 1'b0;
    work_d          = work_q;
    enc_cnt_d       = enc_cnt_q;
    acc_d           = acc_q;
    taken_d         = taken_q;

    if (ctrl_i.enc_load) begin
      work_d    = value_in_i & ValueMask;
      enc_cnt_d = '0;
    end

    if (ctrl_i.enc_step) begin
      stat_o.emit     = 1'b1;
      beat_o.kind     = KIND_BYTE;
      beat_o.out_byte = {enc_more, work_q[DigitBits-1:0]};
      beat_o.cnt      = enc_cnt_q + CntW'(1);
      beat_o.last     = ~enc_more;
      work_d          = work_q >> DigitBits;
      enc_cnt_d       = enc_cnt_q + CntW'(1);
    end

    if (ctrl_i.dec_step) begin
      if (dec_fin) begin
        stat_o.emit = 1'b1;
        beat_o.last = 1'b1;
        if (over32) begin
          beat_o.kind = KIND_ERROR;
          beat_o.err  = ERR_OVER32;
        end else begin
          beat_o.kind  = KIND_VALUE;
          beat_o.value = acc_sum;
          beat_o.cnt   = taken_q + CntW'(1);
        end
        acc_d   = '0;
        taken_d = '0;
      end else if (dec_ovf) begin
        stat_o.emit = 1'b1;
        beat_o.last = 1'b1;
        beat_o.kind = KIND_ERROR;
        beat_o.err  = ERR_OVERFLOW;
        acc_d       = '0;
        taken_d     = '0;
      end else begin
        acc_d   = acc_sum;
        taken_d = taken_q + CntW'(1);
      end
    end

    if (ctrl_i.eob) begin
      stat_o.emit = 1'b1;
      beat_o.last = 1'b1;
      beat_o.kind = KIND_ERROR;
      beat_o.err  = ERR_TRUNCATED;
      acc_d       = '0;
      taken_d     = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_cnt_q <= '0;
      acc_q     <= '0;
      taken_q   <= '0;
    end else begin
      enc_cnt_q <= enc_cnt_d;
      acc_q     <= acc_d;
      taken_q   <= taken_d;
    end
  end

endmodule

// ----- src/lebc_seq.sv -----
// ----------------------------------------------------------------------------
// lebc_seq
// Sequencer: takes input beats and steps the shift unit through an encode.
// ----------------------------------------------------------------------------
module lebc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  lebc_pkg::mode_e   mode_i,
  input  logic              out_free_i,
  input  lebc_pkg::stat_t   stat_i,
  output logic              in_ready_o,
  output lebc_pkg::ctrl_t   ctrl_o
);
  import lebc_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  // only evaluated in idle, where ready follows the output slot
  assign accept = in_valid_i && out_free_i;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free_i;
        if (accept) begin
          case (mode_i)
            MODE_ENCODE: begin
              ctrl_o.enc_load = 1'b1;
              state_d         = ST_ENCODE;
            end
            MODE_DECODE: ctrl_o.dec_step = 1'b1;
            MODE_END:    ctrl_o.eob      = 1'b1;
            default:     ctrl_o          = '0;
          endcase
        end
      end
      ST_ENCODE: begin
        // advance one digit whenever the output slot can take a beat
        if (out_free_i) begin
          ctrl_o.enc_step = 1'b1;
          if (!stat_i.enc_more) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/leb128_varint_codec.sv -----
// ----------------------------------------------------------------------------
// leb128_varint_codec
// Unsigned LEB128 varint encoder and decoder on one stream pair.
// ----------------------------------------------------------------------------
// Each input beat carries a mode in tuser. Encode (mode 0) turns a 64-bit value
// into 1 to 10 output beats, seven bits a beat, low bits first, bit 7 set on
// all but the last; byte_count on each beat gives the bytes emitted so far.
// Decode (mode 1) takes one encoded byte a beat and answers only on the byte
// that ends the varint (value, or an over-32 error when want_32 is set) or on
// a tenth byte that still continues (overflow error). End of buffer (mode 2)
// always answers with a truncation error. Every error clears the decode state;
// mode 3 is dropped silently. An encode loads the value, then steps out its bytes
// in order, and takes no new input beat until its last byte is out. The single
// shared seven-bit shift unit produces one digit a cycle while the output
// register is free; the one-deep output register must be free (empty or being
// drained) before a beat is taken in.
// ----------------------------------------------------------------------------
module leb128_varint_codec (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // value_in[63:0], data_byte[71:64], want_32[72]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // out_byte[7:0], decoded_value[71:8],
                                      // error_code[73:72], byte_count[77:74]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast    // last
);
  import lebc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  beat_t beat;
  beat_t out_q;
  logic  out_valid_q;
  logic  out_free;
  mode_e mode;

  // the output slot can take a beat when empty or drained this cycle
  assign out_free = ~out_valid_q | m_axis_tready;
  assign mode     = mode_e'(s_axis_tuser);

  lebc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .mode_i     (mode),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  lebc_unit u_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .value_in_i  (s_axis_tdata[63:0]),
    .data_byte_i (s_axis_tdata[71:64]),
    .want_32_i   (s_axis_tdata[72]),
    .stat_o      (stat),
    .beat_o      (beat)
  );

  // Output register: load a new beat when the slot is free, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= stat.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && stat.emit) begin
      out_q <= beat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.cnt, out_q.err, out_q.value, out_q.out_byte};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule
